### hdl/cln_pkg.sv
// Shared types, codes and the sequencer microcode for the character LCD nibble sequencer.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package cln_pkg;

  // Request function codes
  localparam logic [2:0] FUNC_CHAR  = 3'd0;
  localparam logic [2:0] FUNC_CMD   = 3'd1;
  localparam logic [2:0] FUNC_POS   = 3'd2;
  localparam logic [2:0] FUNC_CLEAR = 3'd3;
  localparam logic [2:0] FUNC_INIT  = 3'd4;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_FSET   = 3'd0;
  localparam logic [2:0] REG_DCTRL  = 3'd1;
  localparam logic [2:0] REG_EMODE  = 3'd2;
  localparam logic [2:0] REG_PWAIT  = 3'd3;
  localparam logic [2:0] REG_CWAIT  = 3'd4;
  localparam logic [2:0] REG_LWAIT  = 3'd5;

  // Byte sources selected by a microcode word
  localparam logic [2:0] SRC_DATA   = 3'd0;
  localparam logic [2:0] SRC_FSET   = 3'd1;
  localparam logic [2:0] SRC_DCTRL  = 3'd2;
  localparam logic [2:0] SRC_EMODE  = 3'd3;
  localparam logic [2:0] SRC_CONST  = 3'd4;

  // Post-strobe wait selection
  localparam logic [1:0] POST_NONE  = 2'd0;
  localparam logic [1:0] POST_CMD   = 2'd1;
  localparam logic [1:0] POST_LONG  = 2'd2;

  // Program entry points
  localparam logic [4:0] ENTRY_CHAR  = 5'd0;
  localparam logic [4:0] ENTRY_CMD   = 5'd2;
  localparam logic [4:0] ENTRY_POS   = 5'd4;
  localparam logic [4:0] ENTRY_CLEAR = 5'd6;
  localparam logic [4:0] ENTRY_INIT  = 5'd8;
  localparam logic [4:0] LAST_PC     = 5'd22;

  // Cursor address command bit
  localparam logic [7:0] DDRAM_SET  = 8'h80;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] value;
    logic [6:0] column;
    logic [2:0] row;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic [7:0] pre_wait_ms;
    logic [7:0] post_wait_ms;
    logic       short_gap;
    logic       last;
  } strobe_t;

  typedef struct packed {
    logic [7:0] function_set_cmd;
    logic [7:0] display_ctrl_cmd;
    logic [7:0] entry_mode_cmd;
    logic [7:0] power_wait_ms;
    logic [7:0] cmd_wait_ms;
    logic [7:0] long_wait_ms;
  } cfg_t;

  // One control word per strobe
  typedef struct packed {
    logic       rs;
    logic [2:0] src;
    logic       hi;
    logic [3:0] cnib;
    logic       pre_pwr;
    logic [1:0] post;
    logic       gap;
    logic       last;
  } uword_t;

  function automatic uword_t uw(input logic rs, input logic [2:0] src, input logic hi,
                                input logic [3:0] cnib, input logic pre_pwr,
                                input logic [1:0] post, input logic gap, input logic last);
    uword_t w;
    w.rs      = rs;
    w.src     = src;
    w.hi      = hi;
    w.cnib    = cnib;
    w.pre_pwr = pre_pwr;
    w.post    = post;
    w.gap     = gap;
    w.last    = last;
    return w;
  endfunction

  // Microcode ROM
  function automatic uword_t ucode_rom(input logic [4:0] pc);
    uword_t w;
    case (pc)
      // send character
      5'd0:  w = uw(1'b1, SRC_DATA,  1'b1, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b0);
      5'd1:  w = uw(1'b1, SRC_DATA,  1'b0, 4'h0, 1'b0, POST_NONE, 1'b1, 1'b1);
      // raw command
      5'd2:  w = uw(1'b0, SRC_DATA,  1'b1, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b0);
      5'd3:  w = uw(1'b0, SRC_DATA,  1'b0, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b1);
      // set cursor position
      5'd4:  w = uw(1'b0, SRC_DATA,  1'b1, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b0);
      5'd5:  w = uw(1'b0, SRC_DATA,  1'b0, 4'h0, 1'b0, POST_CMD,  1'b0, 1'b1);
      // clear display
      5'd6:  w = uw(1'b0, SRC_CONST, 1'b0, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b0);
      5'd7:  w = uw(1'b0, SRC_CONST, 1'b0, 4'h1, 1'b0, POST_LONG, 1'b0, 1'b1);
      // power-up init: three wake-up nibbles
      5'd8:  w = uw(1'b0, SRC_CONST, 1'b0, 4'h3, 1'b1, POST_CMD,  1'b0, 1'b0);
      5'd9:  w = uw(1'b0, SRC_CONST, 1'b0, 4'h3, 1'b0, POST_CMD,  1'b0, 1'b0);
      5'd10: w = uw(1'b0, SRC_CONST, 1'b0, 4'h3, 1'b0, POST_CMD,  1'b0, 1'b0);
      // function set twice
      5'd11: w = uw(1'b0, SRC_FSET,  1'b1, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b0);
      5'd12: w = uw(1'b0, SRC_FSET,  1'b0, 4'h0, 1'b0, POST_CMD,  1'b0, 1'b0);
      5'd13: w = uw(1'b0, SRC_FSET,  1'b1, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b0);
      5'd14: w = uw(1'b0, SRC_FSET,  1'b0, 4'h0, 1'b0, POST_CMD,  1'b0, 1'b0);
      // display control
      5'd15: w = uw(1'b0, SRC_DCTRL, 1'b1, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b0);
      5'd16: w = uw(1'b0, SRC_DCTRL, 1'b0, 4'h0, 1'b0, POST_CMD,  1'b0, 1'b0);
      // clear
      5'd17: w = uw(1'b0, SRC_CONST, 1'b0, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b0);
      5'd18: w = uw(1'b0, SRC_CONST, 1'b0, 4'h1, 1'b0, POST_LONG, 1'b0, 1'b0);
      // entry mode
      5'd19: w = uw(1'b0, SRC_EMODE, 1'b1, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b0);
      5'd20: w = uw(1'b0, SRC_EMODE, 1'b0, 4'h0, 1'b0, POST_CMD,  1'b0, 1'b0);
      // return home
      5'd21: w = uw(1'b0, SRC_CONST, 1'b0, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b0);
      5'd22: w = uw(1'b0, SRC_CONST, 1'b0, 4'h2, 1'b0, POST_LONG, 1'b0, 1'b1);
      // unused addresses end the program
      default: w = uw(1'b0, SRC_CONST, 1'b0, 4'h0, 1'b0, POST_NONE, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

  // DDRAM base address of each display row
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hdl/cln_cfg_regs.sv
// APB-style configuration register bank for the LCD nibble sequencer.
// Depends on cln_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module cln_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output      logic [31:0]   prdata,
  output      logic          pready,
  output      cln_pkg::cfg_t cfg
);
  import cln_pkg::*;

  logic       wr_en;
  logic [2:0] idx;
  logic [7:0] rd_byte;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  // Register writes; indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.function_set_cmd <= 8'h28;
      cfg.display_ctrl_cmd <= 8'h0C;
      cfg.entry_mode_cmd   <= 8'h06;
      cfg.power_wait_ms    <= 8'd40;
      cfg.cmd_wait_ms      <= 8'd10;
      cfg.long_wait_ms     <= 8'd20;
    end else if (wr_en) begin
      case (idx)
        REG_FSET:  cfg.function_set_cmd <= pwdata[7:0];
        REG_DCTRL: cfg.display_ctrl_cmd <= pwdata[7:0];
        REG_EMODE: cfg.entry_mode_cmd   <= pwdata[7:0];
        REG_PWAIT: cfg.power_wait_ms    <= pwdata[7:0];
        REG_CWAIT: cfg.cmd_wait_ms      <= pwdata[7:0];
        REG_LWAIT: cfg.long_wait_ms     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_FSET:  rd_byte = cfg.function_set_cmd;
      REG_DCTRL: rd_byte = cfg.display_ctrl_cmd;
      REG_EMODE: rd_byte = cfg.entry_mode_cmd;
      REG_PWAIT: rd_byte = cfg.power_wait_ms;
      REG_CWAIT: rd_byte = cfg.cmd_wait_ms;
      REG_LWAIT: rd_byte = cfg.long_wait_ms;
      default:   rd_byte = 8'h00;
    endcase
  end

  assign prdata = {24'h000000, rd_byte};

endmodule

`default_nettype wire

### hdl/char_lcd_nibble_sequencer_top.sv
// Character LCD nibble sequencer: request in, run of enable-strobe descriptors out.
// Depends on cln_pkg (types, microcode ROM) and cln_cfg_regs (register bank).
//
// Usage
//   in_valid/in_stall/in_data carry one request beat (func, value, column, row).
//   out_valid/out_stall/out_data carry one strobe descriptor per beat, high
//   nibble first, with last set on the final strobe of the request.
//   Registers on the APB-style port hold init commands and wait times.
// Timing
//   A request is taken while no program runs and loads the step counter; the
//   first strobe is registered from its entry word, then one strobe leaves per
//   cycle unless the output stalls: char, command, position and clear give 2
//   beats, init gives 15. The single microcode step counter walks the ROM one
//   word a cycle and takes no new request until the last word issues. Position
//   rows above three and unknown function codes are taken and give no beat.
// Reset and stall
//   rst (synchronous) stops any program, drops the output beat and restores the
//   register defaults. While out_stall is high over a held beat, the output
//   register and step counter wait; in_stall stays high until the last word issues.
`default_nettype none

module char_lcd_nibble_sequencer_top (
  input  wire logic             clk,
  input  wire logic             rst,
  // request channel
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire cln_pkg::req_t    in_data,
  // strobe channel
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      cln_pkg::strobe_t out_data,
  // configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output      logic [31:0]      prdata,
  output      logic             pready
);
  import cln_pkg::*;

  cfg_t       cfg;
  logic       busy;
  logic [4:0] pc;
  logic [7:0] data_byte;

  logic       in_take;
  logic       start;
  logic [4:0] entry;
  logic [7:0] pos_addr;
  logic       slot_free;
  logic       issue;
  uword_t     word;
  logic [7:0] src_byte;
  strobe_t    beat_next;

  cln_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Request dispatch: pick the program entry, drop requests with no strobes
  assign in_stall = busy;
  assign in_take  = in_valid && !in_stall;
  assign pos_addr = (row_base(in_data.row[1:0]) + {1'b0, in_data.column}) | DDRAM_SET;

  always_comb begin
    start = 1'b0;
    entry = ENTRY_CHAR;
    case (in_data.func)
      FUNC_CHAR:  begin start = 1'b1;                   entry = ENTRY_CHAR;  end
      FUNC_CMD:   begin start = 1'b1;                   entry = ENTRY_CMD;   end
      FUNC_POS:   begin start = !in_data.row[2];        entry = ENTRY_POS;   end
      FUNC_CLEAR: begin start = 1'b1;                   entry = ENTRY_CLEAR; end
      FUNC_INIT:  begin start = 1'b1;                   entry = ENTRY_INIT;  end
      default:    begin start = 1'b0;                   entry = ENTRY_CHAR;  end
    endcase
  end

  // Current control word and datapath
  assign word      = ucode_rom(pc);
  assign slot_free = !out_valid || !out_stall;
  assign issue     = busy && slot_free;

  always_comb begin
    case (word.src)
      SRC_DATA:  src_byte = data_byte;
      SRC_FSET:  src_byte = cfg.function_set_cmd;
      SRC_DCTRL: src_byte = cfg.display_ctrl_cmd;
      SRC_EMODE: src_byte = cfg.entry_mode_cmd;
      default:   src_byte = {4'h0, word.cnib};
    endcase
  end

  always_comb begin
    beat_next.reg_select  = word.rs;
    beat_next.nibble      = word.hi ? src_byte[7:4] : src_byte[3:0];
    beat_next.pre_wait_ms = word.pre_pwr ? cfg.power_wait_ms : 8'h00;
    case (word.post)
      POST_CMD:  beat_next.post_wait_ms = cfg.cmd_wait_ms;
      POST_LONG: beat_next.post_wait_ms = cfg.long_wait_ms;
      default:   beat_next.post_wait_ms = 8'h00;
    endcase
    beat_next.short_gap = word.gap;
    beat_next.last      = word.last;
  end

  // Sequencer control: step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= ENTRY_CHAR;
    end else if (in_take) begin
      busy <= start;
      pc   <= entry;
    end else if (issue) begin
      busy <= !word.last;
      pc   <= pc + 5'd1;
    end
  end

  // Request byte: character or command, or the computed cursor address
  always_ff @(posedge clk) begin
    if (in_take) begin
      data_byte <= (in_data.func == FUNC_POS) ? pos_addr : in_data.value;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_data <= beat_next;
    end
  end

`ifndef SYNTHESIS
  // The step counter never leaves the program while a request runs
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc <= LAST_PC))
    else $error("step counter outside microcode");

  // An init request starts at the init entry point
  a_init_entry: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_data.func == FUNC_INIT) |=> (busy && pc == ENTRY_INIT))
    else $error("init request did not start its program");

  // Issuing the final word ends the program and presents a last beat
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (issue && word.last) |=> (!busy && out_valid && out_data.last))
    else $error("program did not end on its last word");

  // A running program with a free output slot always produces a beat
  a_progress: assert property (@(posedge clk) disable iff (rst)
    issue |=> out_valid)
    else $error("issued word did not reach the output");
`endif

endmodule

`default_nettype wire
